[rtl/sslp_pkg.sv]
`timescale 1ns / 1ps
// shared types, character codes and decode helpers for the status line parser
package sslp_pkg;

  // line buffer length, positions at LineLen-1 and beyond are dropped
  localparam int unsigned LineLen = 32;
  localparam int unsigned PosW    = $clog2(LineLen);

  typedef logic [PosW-1:0] pos_t;

  localparam pos_t PosLast   = pos_t'(LineLen - 1);
  localparam pos_t PosCmdHi  = pos_t'(3);
  localparam pos_t PosCmdLo  = pos_t'(4);
  localparam pos_t PosValue  = pos_t'(5);
  localparam pos_t PosMinLen = pos_t'(5);

  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharLf     = 8'h0a;
  localparam logic [7:0] CharCr     = 8'h0d;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharColon  = 8'h3a;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperF = 8'h46;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerF = 8'h66;

  localparam logic [7:0] HexUpperOffset = 8'd55;
  localparam logic [7:0] HexLowerOffset = 8'd87;

  // command codes, as read from positions 3 and 4
  localparam logic [6:0] CodeRelays     = 7'd1;
  localparam logic [6:0] CodeRoomTemp   = 7'd10;
  localparam logic [6:0] CodeOutdoor    = 7'd11;
  localparam logic [6:0] CodeLowerSrc   = 7'd12;
  localparam logic [6:0] CodeHotWater   = 7'd13;
  localparam logic [6:0] CodeHeatCirc   = 7'd14;
  localparam logic [6:0] CodeAlarms     = 7'd22;

  localparam logic [31:0] AlarmBias  = 32'd7;
  localparam logic [31:0] MagCap     = 32'h8000_0000;
  localparam logic [31:0] PosMax     = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    KindRelays   = 3'd0,
    KindRoom     = 3'd1,
    KindOutdoor  = 3'd2,
    KindLowerSrc = 3'd3,
    KindHotWater = 3'd4,
    KindHeatCirc = 3'd5,
    KindAlarms   = 3'd6
  } reading_kind_e;

  typedef enum logic [1:0] {
    PhaseBlanks = 2'd0,
    PhaseDigits = 2'd1,
    PhaseDone   = 2'd2
  } phase_e;

  typedef struct packed {
    reading_kind_e kind;
    logic [31:0]   temp;
    logic [31:0]   hexw;
    logic          valid;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (is_digit(c)) begin
      v = c - CharZero;
    end else if ((c >= CharUpperA) && (c <= CharUpperF)) begin
      v = c - HexUpperOffset;
    end else if ((c >= CharLowerA) && (c <= CharLowerF)) begin
      v = c - HexLowerOffset;
    end
    return v[3:0];
  endfunction

  // two-character atoi; a leading minus can never give a known code, so it reads as zero
  function automatic logic [6:0] command_code(input logic [7:0] c0, input logic [7:0] c1);
    logic [6:0] v;
    logic [6:0] d0;
    logic [6:0] d1;
    v  = 7'd0;
    d0 = {3'b000, c0[3:0]};
    d1 = {3'b000, c1[3:0]};
    if (is_blank(c0)) begin
      if (is_digit(c1)) begin
        v = d1;
      end
    end else if (c0 == CharPlus) begin
      if (is_digit(c1)) begin
        v = d1;
      end
    end else if (is_digit(c0)) begin
      if (is_digit(c1)) begin
        v = 7'((d0 << 3) + (d0 << 1) + d1);
      end else begin
        v = d0;
      end
    end
    return v;
  endfunction

endpackage

[rtl/sslp_in_stage.sv]
`timescale 1ns / 1ps
// input register holding one received byte
module sslp_in_stage import sslp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       held_valid_o,
  output logic [7:0] held_byte_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] byte_q;
  logic       take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_byte_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

endmodule

[rtl/sslp_line_decode.sv]
`timescale 1ns / 1ps
// line state, value accumulators and end-of-line decode
module sslp_line_decode import sslp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output logic       emit_o,
  output result_t    result_o
);

  pos_t        pos_q, pos_d;
  logic [7:0]  cmd_hi_q, cmd_hi_d;
  logic [7:0]  cmd_lo_q, cmd_lo_d;
  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] hex_q, hex_d;
  logic        flag_q, flag_d;

  // value feed, computed from the current state
  phase_e      f_phase;
  logic        f_neg;
  logic [31:0] f_acc;
  logic        take_digit;
  logic [35:0] acc_x10;
  logic [6:0]  code;
  logic [31:0] dec_val;

  always_comb begin
    f_phase    = phase_q;
    f_neg      = neg_q;
    f_acc      = acc_q;
    take_digit = 1'b0;
    acc_x10    = ({4'b0000, acc_q} << 3) + ({4'b0000, acc_q} << 1)
               + {32'd0, byte_i[3:0]};
    case (phase_q)
      PhaseBlanks: begin
        if (!is_blank(byte_i)) begin
          f_phase = PhaseDigits;
          if (byte_i == CharMinus) begin
            f_neg = 1'b1;
          end else if (byte_i != CharPlus) begin
            take_digit = 1'b1;
          end
        end
      end
      PhaseDigits: take_digit = 1'b1;
      default: ;
    endcase
    if (take_digit) begin
      if (is_digit(byte_i)) begin
        f_acc = (acc_x10 > {4'b0000, MagCap}) ? MagCap : acc_x10[31:0];
      end else begin
        f_phase = PhaseDone;
      end
    end
  end

  assign code = command_code(cmd_hi_q, cmd_lo_q);

  always_comb begin
    if (neg_q) begin
      dec_val = 32'd0 - acc_q;
    end else begin
      dec_val = acc_q[31] ? PosMax : acc_q;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    cmd_hi_d = cmd_hi_q;
    cmd_lo_d = cmd_lo_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    hex_d    = hex_q;
    flag_d   = flag_q;
    emit_o   = 1'b0;
    result_o = '{kind: KindRelays, temp: 32'd0, hexw: 32'd0, valid: flag_q};

    if (fire_i && (byte_i != CharNul) && (byte_i != CharLf)) begin
      if (byte_i == CharColon) begin
        // restart, the colon sits at position 0
        pos_d    = pos_t'(1);
        cmd_hi_d = 8'd0;
        cmd_lo_d = 8'd0;
        phase_d  = PhaseBlanks;
        neg_d    = 1'b0;
        acc_d    = 32'd0;
        hex_d    = 32'd0;
      end else if (byte_i == CharCr) begin
        if (pos_q > PosMinLen) begin
          emit_o = 1'b1;
          unique case (code)
            CodeRelays: begin
              result_o.kind = KindRelays;
              result_o.hexw = hex_q;
            end
            CodeRoomTemp: begin
              result_o.kind = KindRoom;
              result_o.temp = dec_val;
            end
            CodeOutdoor: begin
              result_o.kind = KindOutdoor;
              result_o.temp = dec_val;
            end
            CodeLowerSrc: begin
              result_o.kind = KindLowerSrc;
              result_o.temp = dec_val;
            end
            CodeHotWater: begin
              result_o.kind = KindHotWater;
              result_o.temp = dec_val;
            end
            CodeHeatCirc: begin
              result_o.kind = KindHeatCirc;
              result_o.temp = dec_val;
            end
            CodeAlarms: begin
              result_o.kind  = KindAlarms;
              result_o.hexw  = AlarmBias - hex_q;
              result_o.valid = 1'b1;
              flag_d         = 1'b1;
            end
            default: emit_o = 1'b0;
          endcase
        end
        pos_d    = '0;
        cmd_hi_d = 8'd0;
        cmd_lo_d = 8'd0;
        phase_d  = PhaseBlanks;
        neg_d    = 1'b0;
        acc_d    = 32'd0;
        hex_d    = 32'd0;
      end else if (pos_q < PosLast) begin
        if (pos_q == PosCmdHi) begin
          cmd_hi_d = byte_i;
        end else if (pos_q == PosCmdLo) begin
          cmd_lo_d = byte_i;
        end else if (pos_q >= PosValue) begin
          hex_d   = {hex_q[27:0], hex_value(byte_i)};
          phase_d = f_phase;
          neg_d   = f_neg;
          acc_d   = f_acc;
        end
        pos_d = pos_q + pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      cmd_hi_q <= 8'd0;
      cmd_lo_q <= 8'd0;
      phase_q  <= PhaseBlanks;
      neg_q    <= 1'b0;
      acc_q    <= 32'd0;
      hex_q    <= 32'd0;
      flag_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      cmd_hi_q <= cmd_hi_d;
      cmd_lo_q <= cmd_lo_d;
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      acc_q    <= acc_d;
      hex_q    <= hex_d;
      flag_q   <= flag_d;
    end
  end

endmodule

[rtl/sslp_out_stage.sv]
`timescale 1ns / 1ps
// result register toward the output channel
module sslp_out_stage import sslp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output result_t result_o
);

  logic    valid_q;
  logic    valid_d;
  result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

[rtl/serial_status_line_parser_unit.sv]
`timescale 1ns / 1ps
// top level of the serial status line parser
//
// Takes received bytes one at a time and collects them into a status line. A ':'
// restarts the line, newline and zero bytes are ignored, and a carriage return
// ends the line. A line longer than five characters is decoded by the command
// code at positions 3 and 4: relay bits (hex), five temperature kinds (signed
// decimal tenths, saturated), or alarm bits (7 minus the hex value), which also
// raise the sticky readings_valid flag. Unknown codes and short lines give no
// word. Timing: a byte goes through an input register, combinational decode
// logic and a result register, which loads the word when its carriage return
// leaves the input register; the block takes one byte per cycle, limited only
// by the result register when a finished word is still waiting to be taken.
module serial_status_line_parser_unit import sslp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         reading_kind_o,
  output logic signed [31:0] temp_tenths_o,
  output logic [31:0]        hex_word_o,
  output logic               readings_valid_o
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       fire;
  logic       emit;
  result_t    dec_result;
  result_t    out_result;

  // a held byte moves on when the result register is free or being drained
  assign fire = held_valid && (!out_valid_o || out_ready_i);

  sslp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .advance_i    (fire),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte)
  );

  // line position, command chars, decimal and hex accumulators, sticky flag
  sslp_line_decode u_line_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .byte_i   (held_byte),
    .emit_o   (emit),
    .result_o (dec_result)
  );

  sslp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .result_i    (dec_result),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign reading_kind_o   = out_result.kind;
  assign temp_tenths_o    = out_result.temp;
  assign hex_word_o       = out_result.hexw;
  assign readings_valid_o = out_result.valid;

`ifndef SYNTHESIS
  // a word is only produced by a carriage return that is moving on
  a_emit_on_cr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (fire && (held_byte == CharCr)))
    else $error("result produced without a carriage return");

  // input backpressure only comes from a stalled result word
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (held_valid && out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled result");

  // alarm words carry no temperature and always report the flag
  a_alarm_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (reading_kind_o == KindAlarms)) |->
      ((temp_tenths_o == 32'sd0) && readings_valid_o))
    else $error("malformed alarm word");

  // the readings flag is sticky across successive words
  a_flag_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_valid_o && readings_valid_o) |=> readings_valid_o)
    else $error("readings flag dropped");
`endif

endmodule
